// ----- rtl/core/gof_pkg.sv -----
// Shared constants, kind codes and the request/response structs of the
// outline flattener. No dependencies; every other file in rtl/core uses it.
`default_nettype none

package gof_pkg;

    // Default number of chords per quadratic curve
    localparam int SEGMENTS_DEF = 5;

    // Field widths
    localparam int COORD_W = 16;   // font unit coordinate
    localparam int POS_W   = 40;   // signed Q24.16 position
    localparam int SCALE_W = 32;   // unsigned Q8.24 scale

    // Datapath widths: weighted sum, scaled product, long division
    localparam int NUM_W      = 26;
    localparam int PROD_W     = 57;
    localparam int FRAC_SHIFT = 8;
    localparam int DIV_W      = 48;
    localparam int DIV_STEP   = 8;
    localparam int DIV_CYC    = DIV_W / DIV_STEP;

    localparam logic [SCALE_W-1:0] SCALE_RST = 32'h0100_0000;

    // Vertex kinds; every other code behaves as a move
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_CURVE = 2'd2;

    // Request to the shared scale unit
    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
    } t_su_req;

    // Response from the shared scale unit
    typedef struct packed {
        logic                    done;
        logic signed [POS_W-1:0] quot;
    } t_su_rsp;

endpackage

`default_nettype wire

// ----- rtl/core/gof_scale_unit.sv -----
// Shared scale unit: multiplies a weighted coordinate sum by the Q8.24 scale
// and floor-divides by DEN * 256 with a radix-256 long division. Uses gof_pkg.
`default_nettype none

module gof_scale_unit #(
    parameter int DEN = gof_pkg::SEGMENTS_DEF * gof_pkg::SEGMENTS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  [gof_pkg::SCALE_W-1:0]        i_scale,
    input  wire  gof_pkg::t_su_req             i_req,
    output gof_pkg::t_su_rsp                   o_rsp
);

    localparam int REM_W = $clog2(DEN) + 1;
    localparam int CNT_W = $clog2(gof_pkg::DIV_CYC + 1);
    localparam logic [REM_W:0]   DEN_V    = (REM_W + 1)'(DEN);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(gof_pkg::DIV_CYC - 1);

    typedef enum logic [3:0] {
        U_IDLE = 4'b0001,
        U_PREP = 4'b0010,
        U_DIV  = 4'b0100,
        U_DONE = 4'b1000
    } t_su_state;

    t_su_state                          r_state, n_state;
    logic [CNT_W-1:0]                   r_cnt;
    logic signed [gof_pkg::PROD_W-1:0]  r_prod;
    logic [gof_pkg::DIV_W-1:0]          r_mq;
    logic [REM_W-1:0]                   r_rem;
    logic                               r_neg;

    logic signed [gof_pkg::SCALE_W:0]   w_scale_s;
    logic signed [gof_pkg::PROD_W-1:0]  w_prod;
    logic [gof_pkg::DIV_W-1:0]          w_mag;
    logic [gof_pkg::DIV_W-1:0]          n_mq;
    logic [REM_W-1:0]                   n_rem;

    // Scale product; the scale is unsigned so extend it with a zero
    assign w_scale_s = $signed({1'b0, i_scale});
    assign w_prod    = i_req.num * w_scale_s;

    // Floor shift by 256, then fold negatives by inversion: floor(s/D) = ~floor(~s/D)
    assign w_mag = r_prod[gof_pkg::PROD_W-1] ? ~r_prod[gof_pkg::FRAC_SHIFT +: gof_pkg::DIV_W]
                                             :  r_prod[gof_pkg::FRAC_SHIFT +: gof_pkg::DIV_W];

    // One radix-256 digit of long division by DEN: eight compare-subtract steps
    always_comb begin
        logic [REM_W:0]            v_t;
        logic [REM_W-1:0]          v_rem;
        logic [gof_pkg::DIV_W-1:0] v_mq;
        v_rem = r_rem;
        v_mq  = r_mq;
        for (int i = 0; i < gof_pkg::DIV_STEP; i++) begin
            v_t = {v_rem, v_mq[gof_pkg::DIV_W-1]};
            if (v_t >= DEN_V) begin
                v_rem = REM_W'(v_t - DEN_V);
                v_mq  = {v_mq[gof_pkg::DIV_W-2:0], 1'b1};
            end else begin
                v_rem = REM_W'(v_t);
                v_mq  = {v_mq[gof_pkg::DIV_W-2:0], 1'b0};
            end
        end
        n_rem = v_rem;
        n_mq  = v_mq;
    end

    // Sequence multiply, prepare, divide, report
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            U_IDLE: begin
                if (i_req.start) n_state = U_PREP;
            end
            U_PREP: n_state = U_DIV;
            U_DIV: begin
                if (r_cnt == CNT_LAST) n_state = U_DONE;
            end
            U_DONE: n_state = U_IDLE;
            default: n_state = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == U_DIV) r_cnt <= r_cnt + CNT_W'(1);
            else                  r_cnt <= '0;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == U_IDLE && i_req.start) r_prod <= w_prod;
        if (r_state == U_PREP) begin
            r_neg <= r_prod[gof_pkg::PROD_W-1];
            r_mq  <= w_mag;
            r_rem <= '0;
        end else if (r_state == U_DIV) begin
            r_mq  <= n_mq;
            r_rem <= n_rem;
        end
    end

    // Undo the inversion on the quotient
    assign o_rsp.done = (r_state == U_DONE);
    assign o_rsp.quot = r_neg ? ~r_mq[gof_pkg::POS_W-1:0] : r_mq[gof_pkg::POS_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/glyph_outline_flattener_top.sv -----
// Outline flattener top level: vertex sequencer, forward-difference chord
// stepping and output register around gof_scale_unit. Uses gof_pkg.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+---------------------------------
//  s_axis   | in  | tvalid / tready              | tdata end/ctrl, tuser kind/new
//  m_axis   | out | tvalid / tready              | tdata seg start/end, tlast
//  cfg      | in  | we (no wait)                 | wdata scale_factor Q8.24
//
// Each coordinate passes through the shared multiply/divide unit (multiply,
// prepare, radix-256 long division, report); a point is x then y plus an
// emit step. A move or line scales one point, a curve SEGMENTS points, one
// per chord. The input is ready only while the sequencer is idle;
// a stalled output register holds the sequencer in its emit step.
// Reset is synchronous and active low; previous points clear to zero.
`default_nettype none

module glyph_outline_flattener_top #(
    parameter int SEGMENTS = gof_pkg::SEGMENTS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [gof_pkg::SCALE_W-1:0]  i_cfg_wdata,
    input  wire                          i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  wire  [63:0]                  i_s_axis_tdata,  // end_x, end_y, ctrl_x, ctrl_y
    input  wire  [2:0]                   i_s_axis_tuser,  // vertex_kind[1:0], new_shape
    output logic                         o_m_axis_tvalid,
    input  wire                          i_m_axis_tready,
    output logic [159:0]                 o_m_axis_tdata,  // start_x, start_y, end_x, end_y
    output logic                         o_m_axis_tlast   // last_segment
);

    localparam int NUM_W = gof_pkg::NUM_W;
    localparam int POS_W = gof_pkg::POS_W;
    localparam int CW    = gof_pkg::COORD_W;
    localparam int DEN   = SEGMENTS * SEGMENTS;
    localparam int J_W   = $clog2(SEGMENTS + 1);
    localparam logic signed [NUM_W-1:0] K_N2   = NUM_W'(DEN);
    localparam logic signed [NUM_W-1:0] K_2N   = NUM_W'(2 * SEGMENTS);
    localparam logic [J_W-1:0]          J_LAST = J_W'(SEGMENTS);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LAUNCH = 4'b0010,
        S_WAIT   = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    // Forward-difference start values of one axis
    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic signed [NUM_W-1:0] dif;
        logic signed [NUM_W-1:0] dd;
    } t_fd;

    t_state                     r_state, n_state;
    logic [gof_pkg::SCALE_W-1:0] r_scale;
    logic signed [CW-1:0]       r_raw_x, r_raw_y;
    logic signed [POS_W-1:0]    r_px, r_py;
    logic signed [POS_W-1:0]    r_qx, r_qy;
    logic [1:0]                 r_kind;
    t_fd                        r_fd_x, r_fd_y;
    logic [J_W-1:0]             r_j;
    logic                       r_axis;
    logic                       r_ovalid;
    logic [159:0]               r_odata;
    logic                       r_olast;

    logic                       w_accept;
    logic [1:0]                 w_kind;
    logic                       w_new;
    logic signed [CW-1:0]       w_ex, w_ey, w_cx, w_cy, w_p0x, w_p0y;
    t_fd                        w_fd_x, w_fd_y;
    logic                       w_has_out, w_more, w_last, w_emit;
    gof_pkg::t_su_req           w_req;
    gof_pkg::t_su_rsp           w_rsp;

    // Start values: chord 1 sum, its first difference and the constant second one
    function automatic t_fd fd_init(input logic signed [CW-1:0] p0,
                                    input logic signed [CW-1:0] c,
                                    input logic signed [CW-1:0] e,
                                    input logic                 curve);
        logic signed [NUM_W-1:0] v_p0, v_c, v_e, v_a, v_b;
        t_fd                     v_fd;
        v_p0 = NUM_W'(p0);
        v_c  = NUM_W'(c);
        v_e  = NUM_W'(e);
        v_a  = v_p0 - (v_c <<< 1) + v_e;
        v_b  = K_2N * (v_c - v_p0);
        if (curve) begin
            v_fd.num = K_N2 * v_p0 + v_b + v_a;
            v_fd.dif = v_b + v_a + (v_a <<< 1);
        end else begin
            v_fd.num = K_N2 * v_e;
            v_fd.dif = '0;
        end
        v_fd.dd = v_a <<< 1;
        return v_fd;
    endfunction

    // Unpack the vertex request
    assign w_kind = i_s_axis_tuser[1:0];
    assign w_new  = i_s_axis_tuser[2];
    assign w_ex   = i_s_axis_tdata[15:0];
    assign w_ey   = i_s_axis_tdata[31:16];
    assign w_cx   = i_s_axis_tdata[47:32];
    assign w_cy   = i_s_axis_tdata[63:48];
    assign w_p0x  = w_new ? '0 : r_raw_x;
    assign w_p0y  = w_new ? '0 : r_raw_y;
    assign w_fd_x = fd_init(w_p0x, w_cx, w_ex, w_kind == gof_pkg::KIND_CURVE);
    assign w_fd_y = fd_init(w_p0y, w_cy, w_ey, w_kind == gof_pkg::KIND_CURVE);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid & o_s_axis_tready;

    // Emit decisions for the point just scaled
    assign w_has_out = (r_kind == gof_pkg::KIND_LINE) || (r_kind == gof_pkg::KIND_CURVE);
    assign w_more    = (r_kind == gof_pkg::KIND_CURVE) && (r_j != J_LAST);
    assign w_last    = !w_more;
    assign w_emit    = (r_state == S_EMIT) && (!w_has_out || !r_ovalid || i_m_axis_tready);

    // Drive the shared unit
    assign w_req.start = (r_state == S_LAUNCH);
    assign w_req.num   = r_axis ? r_fd_y.num : r_fd_x.num;

    gof_scale_unit #(
        .DEN (DEN)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scale (r_scale),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_LAUNCH;
            end
            S_LAUNCH: n_state = S_WAIT;
            S_WAIT: begin
                if (w_rsp.done) n_state = r_axis ? S_EMIT : S_LAUNCH;
            end
            S_EMIT: begin
                if (w_emit) n_state = w_more ? S_LAUNCH : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_scale  <= gof_pkg::SCALE_RST;
            r_raw_x  <= '0;
            r_raw_y  <= '0;
            r_px     <= '0;
            r_py     <= '0;
            r_j      <= J_W'(1);
            r_axis   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_scale <= i_cfg_wdata;
            // take a vertex: clear the pen on a new shape, record the raw end
            if (w_accept) begin
                r_raw_x <= w_ex;
                r_raw_y <= w_ey;
                r_j     <= J_W'(1);
                r_axis  <= 1'b0;
                if (w_new) begin
                    r_px <= '0;
                    r_py <= '0;
                end
            end
            if (r_state == S_WAIT && w_rsp.done) r_axis <= !r_axis;
            // advance the pen to the point just scaled
            if (w_emit) begin
                r_px <= r_qx;
                r_py <= r_qy;
                if (w_more) r_j <= r_j + J_W'(1);
            end
            if (w_emit && w_has_out)   r_ovalid <= 1'b1;
            else if (i_m_axis_tready)  r_ovalid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= w_kind;
            r_fd_x <= w_fd_x;
            r_fd_y <= w_fd_y;
        end else if (w_emit && w_more) begin
            r_fd_x.num <= r_fd_x.num + r_fd_x.dif;
            r_fd_x.dif <= r_fd_x.dif + r_fd_x.dd;
            r_fd_y.num <= r_fd_y.num + r_fd_y.dif;
            r_fd_y.dif <= r_fd_y.dif + r_fd_y.dd;
        end
        if (r_state == S_WAIT && w_rsp.done) begin
            if (r_axis) r_qy <= w_rsp.quot;
            else        r_qx <= w_rsp.quot;
        end
        if (w_emit && w_has_out) begin
            r_odata <= {r_qy, r_qx, r_py, r_px};
            r_olast <= w_last;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;

`ifndef ASSERT_OFF
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_WAIT))
        else $error("scale unit reported outside the wait step");

    a_accept_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_LAUNCH) && !r_axis)
        else $error("accepted vertex did not launch the x coordinate");

    a_chord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_j >= J_W'(1)) && (r_j <= J_LAST))
        else $error("chord index out of range");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_has_out) |=> o_m_axis_tvalid && (o_m_axis_tlast == $past(w_last)))
        else $error("emitted segment not presented with its last flag");
`endif

endmodule

`default_nettype wire
